[rtl/sls_pkg.sv]
// Shared constants, codes and memory request type for the sequential list store.
`default_nettype none
package sls_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [FUNC_W-1:0] FN_INSERT       = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FN_DELETE_VALUE = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FN_DELETE_AT    = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FN_MODIFY_VALUE = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FN_MODIFY_AT    = FUNC_W'(4);
  localparam logic [FUNC_W-1:0] FN_READ         = FUNC_W'(5);

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage
`default_nettype wire

[rtl/sls_ram.sv]
// Entry memory: one write port and one registered read port.
`default_nettype none
module sls_ram (
  input  wire logic                      clk,
  input  wire sls_pkg::mem_req_t         req,
  output logic [sls_pkg::DATA_W-1:0]     rd_data
);
  import sls_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/sequential_list_store.sv]
// Top level of the sequential list store: operation sequencer around the entry memory.
//
// An operation beat is taken at a rising edge where start is high and busy is low.
// The payload names one of six operations (insert, delete value, delete at position,
// modify value, modify at position, read) with a position, a value and a new value.
// Every beat produces exactly one result beat: out_valid is high for one cycle with
// out_ok, out_read_value and out_length, and the receiver cannot hold it off.
// busy stays high from the cycle after acceptance until the result cycle ends.
// Entries live in a single memory with a registered read; shifts and scans stream
// through it one entry per cycle, reading one address while writing back another.
// A failed operation goes straight to the result beat. Modify at position writes its
// entry in the put state; a read addresses the memory, then takes the registered data.
// An insert first shifts the entries at and above its position up, then writes the new
// entry; delete at position shifts the later entries down. Modify value scans every entry
// and rewrites each match; delete value scans to the first match, then shifts the later
// entries down. The next beat is taken only after the result beat, as busy holds it off.
// Reset empties the list; entry contents need no clearing because only entries
// below the length are ever read.
`default_nettype none
module sequential_list_store (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [sls_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [sls_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [sls_pkg::DATA_W-1:0] in_value,
  input  wire logic signed [sls_pkg::DATA_W-1:0] in_new_value,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [sls_pkg::DATA_W-1:0] out_read_value,
  output logic [sls_pkg::LEN_W-1:0]         out_length
);
  import sls_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SHIFT     = 7'b0000010,
    ST_SCAN      = 7'b0000100,
    ST_PUT       = 7'b0001000,
    ST_READ      = 7'b0010000,
    ST_READ_WAIT = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] nval_r, nval_nxt;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] rdv_r, rdv_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  src_r, src_nxt;
  logic [IDX_W-1:0]  tag_r, tag_nxt;
  logic              pend_r, pend_nxt;
  logic              dir_up_r, dir_up_nxt;

  mem_req_t          req;
  logic [DATA_W-1:0] rd_data;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              match;
  logic              accept;

  sls_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign pos_c  = CMP_W'(in_position);
  assign cnt_c  = CMP_W'(count_r);
  assign match  = (rd_data == val_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    func_nxt   = func_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    nval_nxt   = nval_r;
    ok_nxt     = ok_r;
    rdv_nxt    = rdv_r;
    rem_nxt    = rem_r;
    src_nxt    = src_r;
    tag_nxt    = tag_r;
    pend_nxt   = pend_r;
    dir_up_nxt = dir_up_r;
    req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          pos_nxt   = IDX_W'(in_position);
          val_nxt   = in_value;
          nval_nxt  = in_new_value;
          ok_nxt    = 1'b0;
          rdv_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
          case (in_func)
            FN_INSERT: begin
              if ((count_r < CNT_W'(CAPACITY)) && (pos_c <= cnt_c)) begin
                rem_nxt    = CNT_W'(cnt_c - pos_c);
                src_nxt    = IDX_W'(count_r - CNT_W'(1));
                dir_up_nxt = 1'b1;
                state_nxt  = ST_SHIFT;
              end
            end
            FN_DELETE_AT: begin
              if (pos_c < cnt_c) begin
                rem_nxt    = CNT_W'(cnt_c - pos_c - CMP_W'(1));
                src_nxt    = IDX_W'(pos_c + CMP_W'(1));
                dir_up_nxt = 1'b0;
                state_nxt  = ST_SHIFT;
              end
            end
            FN_DELETE_VALUE, FN_MODIFY_VALUE: begin
              if (count_r != '0) begin
                rem_nxt   = count_r;
                src_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            FN_MODIFY_AT: begin
              if (pos_c < cnt_c) begin
                state_nxt = ST_PUT;
              end
            end
            FN_READ: begin
              if (pos_c < cnt_c) begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        if (pend_r) begin
          req.we    = 1'b1;
          req.waddr = dir_up_r ? (tag_r + IDX_W'(1)) : (tag_r - IDX_W'(1));
          req.wdata = rd_data;
        end
        if (rem_r != '0) begin
          req.re   = 1'b1;
          req.raddr = src_r;
          tag_nxt  = src_r;
          pend_nxt = 1'b1;
          src_nxt  = dir_up_r ? (src_r - IDX_W'(1)) : (src_r + IDX_W'(1));
          rem_nxt  = rem_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (func_r == FN_INSERT) begin
              state_nxt = ST_PUT;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              ok_nxt    = 1'b1;
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_SCAN: begin
        if (pend_r && match && (func_r == FN_DELETE_VALUE)) begin
          rem_nxt    = CNT_W'(count_r - CNT_W'(1) - CNT_W'(tag_r));
          src_nxt    = tag_r + IDX_W'(1);
          dir_up_nxt = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = ST_SHIFT;
        end else begin
          if (pend_r && match) begin
            req.we    = 1'b1;
            req.waddr = tag_r;
            req.wdata = nval_r;
          end
          if (rem_r != '0) begin
            req.re    = 1'b1;
            req.raddr = src_r;
            tag_nxt   = src_r;
            pend_nxt  = 1'b1;
            src_nxt   = src_r + IDX_W'(1);
            rem_nxt   = rem_r - CNT_W'(1);
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              ok_nxt    = 1'b1;
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_PUT: begin
        req.we    = 1'b1;
        req.waddr = pos_r;
        req.wdata = val_r;
        if (func_r == FN_INSERT) begin
          count_nxt = count_r + CNT_W'(1);
        end
        ok_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_READ: begin
        req.re    = 1'b1;
        req.raddr = pos_r;
        state_nxt = ST_READ_WAIT;
      end

      ST_READ_WAIT: begin
        rdv_nxt   = rd_data;
        ok_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    nval_r   <= nval_nxt;
    ok_r     <= ok_nxt;
    rdv_r    <= rdv_nxt;
    rem_r    <= rem_nxt;
    src_r    <= src_nxt;
    tag_r    <= tag_nxt;
    dir_up_r <= dir_up_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_DONE);
  assign out_ok         = ok_r;
  assign out_read_value = $signed(rdv_r);
  assign out_length     = LEN_W'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length exceeds capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_result_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy still high after the result beat");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> $stable(count_r))
    else $error("length changed at acceptance");
`endif

endmodule
`default_nettype wire

[verif/sequential_list_store_test.sv]
// Self-checking testbench for the sequential list store: directed table, then random operations.
`timescale 1ns / 1ps
module sequential_list_store_test;
  import sls_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = FUNC_W'(6);
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = FUNC_W'(7);
  localparam int RANDOM_OPS = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam logic [DATA_W-1:0] EDGE_VALUES [0:3] =
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] rd;
    logic [LEN_W-1:0]  len;
  } list_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] nval;
    logic [7:0]        reps;
    logic              known;
    list_result_t      want;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [FUNC_W-1:0] in_func;
  logic [POS_W-1:0] in_position;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_new_value;
  logic out_valid;
  logic out_ok;
  logic signed [DATA_W-1:0] out_read_value;
  logic [LEN_W-1:0] out_length;

  logic [DATA_W-1:0] list_mem [0:CAPACITY-1];
  int list_len;
  list_result_t pending_results [$];
  logic known_valid;
  list_result_t known_want;
  int fail_count;

  op_row_t op_script [0:25] = '{
    '{FN_READ,         4'd0,  32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_DELETE_VALUE, 4'd0,  32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_DELETE_AT,    4'd0,  32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_MODIFY_VALUE, 4'd0,  32'h0000_0000, 32'h0000_0001, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_MODIFY_AT,    4'd0,  32'h0000_0005, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_SPARE_LO,     4'd0,  32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_INSERT,       4'd15, 32'h0000_0009, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd0}},
    '{FN_INSERT,       4'd0,  32'h8000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd1}},
    '{FN_INSERT,       4'd1,  32'h7FFF_FFFF, 32'h0000_0000, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd2}},
    '{FN_INSERT,       4'd0,  32'hFFFF_FFFF, 32'h0000_0000, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd3}},
    '{FN_INSERT,       4'd1,  32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd4}},
    '{FN_INSERT,       4'd2,  32'h0000_0007, 32'h0000_0000, 8'd12, 1'b0, '0},
    '{FN_INSERT,       4'd0,  32'h0000_0003, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd16}},
    '{FN_READ,         4'd15, 32'h0000_0000, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{FN_SPARE_HI,     4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd16}},
    '{FN_MODIFY_VALUE, 4'd0,  32'h0000_0007, 32'h8000_0001, 8'd1,  1'b0, '0},
    '{FN_DELETE_VALUE, 4'd0,  32'h1234_5678, 32'h0000_0000, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd16}},
    '{FN_DELETE_VALUE, 4'd0,  32'h8000_0000, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{FN_MODIFY_VALUE, 4'd0,  32'h1234_5678, 32'h0000_0000, 8'd1,  1'b1, '{1'b1, 32'h0, 5'd15}},
    '{FN_DELETE_AT,    4'd15, 32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd15}},
    '{FN_MODIFY_AT,    4'd14, 32'h7FFF_FFFF, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{FN_MODIFY_AT,    4'd15, 32'h0000_0001, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd15}},
    '{FN_READ,         4'd15, 32'h0000_0000, 32'h0000_0000, 8'd1,  1'b1, '{1'b0, 32'h0, 5'd15}},
    '{FN_DELETE_AT,    4'd14, 32'h0000_0000, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{FN_DELETE_AT,    4'd0,  32'h0000_0000, 32'h0000_0000, 8'd1,  1'b0, '0},
    '{FN_READ,         4'd0,  32'h0000_0000, 32'h0000_0000, 8'd1,  1'b0, '0}
  };

  sequential_list_store u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_position    (in_position),
    .in_value       (in_value),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_length     (out_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void drop_entry(input int at);
    int i;
    for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] f,
                                                 input logic [POS_W-1:0] p,
                                                 input logic [DATA_W-1:0] v,
                                                 input logic [DATA_W-1:0] nv);
    list_result_t r;
    int i;
    int hit;
    r = '0;
    case (f)
      FN_INSERT: begin
        if (list_len < CAPACITY && int'(p) <= list_len) begin
          for (i = list_len; i > int'(p); i--) list_mem[i] = list_mem[i - 1];
          list_mem[p] = v;
          list_len++;
          r.ok = 1'b1;
        end
      end
      FN_DELETE_VALUE: begin
        if (list_len != 0) begin
          hit = -1;
          for (i = 0; i < list_len; i++)
            if (hit < 0 && list_mem[i] == v) hit = i;
          if (hit >= 0) drop_entry(hit);
          r.ok = 1'b1;
        end
      end
      FN_DELETE_AT: begin
        if (int'(p) < list_len) begin
          drop_entry(int'(p));
          r.ok = 1'b1;
        end
      end
      FN_MODIFY_VALUE: begin
        if (list_len != 0) begin
          for (i = 0; i < list_len; i++)
            if (list_mem[i] == v) list_mem[i] = nv;
          r.ok = 1'b1;
        end
      end
      FN_MODIFY_AT: begin
        if (int'(p) < list_len) begin
          list_mem[p] = v;
          r.ok = 1'b1;
        end
      end
      FN_READ: begin
        if (int'(p) < list_len) begin
          r.rd = list_mem[p];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.len = LEN_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    list_result_t predicted;
    list_result_t head;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected (ok %0b, read %0d, length %0d)",
                   $time, out_ok, out_read_value, out_length);
          fail_count++;
        end else begin
          head = pending_results.pop_front();
          if (out_ok !== head.ok) begin
            $display("%0t: ok mismatch, expected %0b, actual %0b", $time, head.ok, out_ok);
            fail_count++;
          end
          if (out_read_value !== head.rd) begin
            $display("%0t: read_value mismatch, expected %0d, actual %0d",
                     $time, $signed(head.rd), out_read_value);
            fail_count++;
          end
          if (out_length !== head.len) begin
            $display("%0t: length mismatch, expected %0d, actual %0d",
                     $time, head.len, out_length);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_list_op(in_func, in_position, in_value, in_new_value);
        pending_results.push_back(known_valid ? known_want : predicted);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic issue_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                          input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] nv,
                          input logic known, input list_result_t want);
    start = 1'b1;
    in_func = f;
    in_position = p;
    in_value = v;
    in_new_value = nv;
    known_valid = known;
    known_want = want;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && list_len > 0) pick_value = list_mem[$urandom_range(0, list_len - 1)];
    else if (r < 55) pick_value = EDGE_VALUES[$urandom_range(0, 3)];
    else if (r < 75) pick_value = DATA_W'($urandom_range(0, 7));
    else pick_value = $urandom;
  endfunction

  task automatic random_op(input int fill_goal);
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0] p;
    int r;
    r = $urandom_range(0, 99);
    if (r < ((list_len < fill_goal) ? 60 : 12)) begin
      f = FN_INSERT;
    end else if (r < 97) begin
      case ($urandom_range(0, 4))
        0: f = FN_DELETE_VALUE;
        1: f = FN_DELETE_AT;
        2: f = FN_MODIFY_VALUE;
        3: f = FN_MODIFY_AT;
        default: f = FN_READ;
      endcase
    end else begin
      f = $urandom_range(0, 1) ? FN_SPARE_LO : FN_SPARE_HI;
    end
    if (list_len == 0 || $urandom_range(0, 4) == 0)
      p = POS_W'($urandom_range(0, 15));
    else if (f == FN_INSERT)
      p = POS_W'($urandom_range(0, (list_len > 15) ? 15 : list_len));
    else
      p = POS_W'($urandom_range(0, list_len - 1));
    issue_op(f, p, pick_value(), pick_value(), 1'b0, '0);
  endtask

  initial begin : stimulus
    int row;
    int sent;
    int k;
    int burst_len;
    int fill_goal;
    bit quiet;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FN_READ;
    in_position = '0;
    in_value = '0;
    in_new_value = '0;
    known_valid = 1'b0;
    known_want = '0;
    list_len = 0;
    fail_count = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (row = 0; row < $size(op_script); row++)
      repeat (op_script[row].reps)
        issue_op(op_script[row].func, op_script[row].pos, op_script[row].val,
                 op_script[row].nval, op_script[row].known, op_script[row].want);
    drain_results();

    sent = 0;
    while (sent < RANDOM_OPS) begin
      fill_goal = $urandom_range(0, CAPACITY);
      burst_len = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 2) == 0);
      if (sent == RANDOM_OPS / 2 || $urandom_range(0, 7) == 0) drain_results();
      for (k = 0; k < burst_len && sent < RANDOM_OPS; k++) begin
        if (!quiet && sent < RANDOM_OPS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          start = 1'b0;
          repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        random_op(fill_goal);
        sent++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
